// ----- sv/kt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kt_pkg: shared types and constants of the keyed table
// Table geometry, request codes, entry layout and the memory request bundle.
// ----------------------------------------------------------------------------
package kt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int KEY_BITS      = 24;

  localparam int CONTACT_KEY_W = 24;
  localparam int NAME_W        = 64;
  localparam int REQ_W         = 2;

  // effective stored key width: the request carries 24 bits
  localparam int KEY_W   = (KEY_BITS < CONTACT_KEY_W) ? KEY_BITS : CONTACT_KEY_W;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENTRY_W = NAME_W + KEY_W;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 72;

  typedef logic [REQ_W-1:0] req_type_t;

  localparam req_type_t OP_ADD  = 2'd0;
  localparam req_type_t OP_DEL  = 2'd1;
  localparam req_type_t OP_FIND = 2'd2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [NAME_W-1:0]  name_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ----- sv/kt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/kt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kt_ctrl: request sequencer of the keyed table
// Scans the entry memory one entry per cycle, tracks the first key match and
// the first free entry, then writes back and drives the result register.
// ----------------------------------------------------------------------------
module kt_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [kt_pkg::REQ_W-1:0]      in_tuser,
  input  wire logic [kt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [kt_pkg::OUT_DATA_W-1:0]      out_tdata,
  output kt_pkg::mem_req_t                   mem_req,
  input  wire kt_pkg::entry_t                mem_rdata
);
  import kt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_ACT   = 4'b1000
  } state_t;

  state_t    state_r, state_nxt;
  idx_t      cnt_r, cnt_nxt;
  logic      rd_vld_r;
  idx_t      rd_idx_r;
  logic      rd_ent_vld_r;
  req_type_t op_r;
  key_t      key_r;
  name_t     name_r;
  logic      match_r, match_nxt;
  idx_t      match_idx_r, match_idx_nxt;
  name_t     match_name_r, match_name_nxt;
  logic      free_r, free_nxt;
  idx_t      free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic      ovf_r, ovf_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      out_found_r;
  name_t     out_name_r;
  logic      out_ovf_r;
  logic      out_load;
  logic      hit, empty;
  key_t      rd_key;
  name_t     rd_name;

  assign rd_key  = mem_rdata[KEY_W-1:0];
  assign rd_name = mem_rdata[ENTRY_W-1:KEY_W];
  assign hit     = rd_vld_r && rd_ent_vld_r && (rd_key == key_r) && !match_r;
  assign empty   = rd_vld_r && !rd_ent_vld_r && !free_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - NAME_W - 2){1'b0}}, out_ovf_r, out_name_r, out_found_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    match_nxt      = match_r;
    match_idx_nxt  = match_idx_r;
    match_name_nxt = match_name_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_load       = 1'b0;
    mem_req.we     = 1'b0;
    mem_req.waddr  = match_idx_r;
    mem_req.wdata  = {name_r, key_r};
    mem_req.raddr  = cnt_r;

    if (hit) begin
      match_nxt      = 1'b1;
      match_idx_nxt  = rd_idx_r;
      match_name_nxt = rd_name;
    end
    if (empty) begin
      free_nxt     = 1'b1;
      free_idx_nxt = rd_idx_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
          match_nxt = 1'b0;
          free_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == idx_t'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_ACT;
      end
      ST_ACT: begin
        unique case (op_r)
          OP_ADD: begin
            state_nxt = ST_IDLE;
            if (match_r) begin
              mem_req.we = 1'b1;
            end else if (free_r) begin
              mem_req.we              = 1'b1;
              mem_req.waddr           = free_idx_r;
              valid_nxt[free_idx_r]   = 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          OP_DEL: begin
            state_nxt = ST_IDLE;
            if (match_r) begin
              valid_nxt[match_idx_r] = 1'b0;
            end
          end
          default: begin
            if (!out_valid_r || out_tready) begin
              out_load      = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
      valid_r     <= valid_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      match_r     <= match_nxt;
      free_r      <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    rd_idx_r     <= cnt_r;
    rd_ent_vld_r <= valid_r[cnt_r];
    match_idx_r  <= match_idx_nxt;
    match_name_r <= match_name_nxt;
    free_idx_r   <= free_idx_nxt;
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      key_r  <= in_tdata[KEY_W-1:0];
      name_r <= in_tdata[CONTACT_KEY_W +: NAME_W];
    end
    if (out_load) begin
      out_found_r <= match_r;
      out_name_r  <= match_r ? match_name_r : '0;
      out_ovf_r   <= ovf_r;
    end
  end

endmodule
`default_nettype wire

// ----- sv/keyed_table_add_delete_find.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_table_add_delete_find: key-value table with add, delete and find
// Top level: request sequencer plus the key/name entry memory.
// ----------------------------------------------------------------------------
// Each request (add, delete, find; code 3 acts as find) holds the block from
// one input transfer to the earliest next one: the sequencer reads the
// key/name memory through its single read port one entry per cycle, then
// waits out the registered read, writes back, sets or clears a valid bit or
// loads the result, and returns to idle to take the next transfer. Requests
// are handled one at a time; the next transfer is taken once the previous
// request completes, even while a find result still waits on the output,
// but a find whose result register is still occupied holds until that
// result transfers, stalling the input. Only a find gives a result transfer.
// Entry valid bits live in flip-flops and clear at reset, so no clearing
// pass is needed. An add of a new key into a full table is dropped and sets
// the sticky overflow flag, reported with every find result.
module keyed_table_add_delete_find (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [kt_pkg::REQ_W-1:0]      in_tuser,  // [1:0] req_type
  input  wire logic [kt_pkg::IN_DATA_W-1:0]  in_tdata,  // [23:0] contact_key, [87:24] name_value
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [kt_pkg::OUT_DATA_W-1:0]      out_tdata  // [0] found, [64:1] name_out,
                                                        // [65] overflowed, [71:66] zero
);
  import kt_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;

  kt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  kt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
